// ===== hw/rtl/rcfd_pkg.sv =====
// Shared types, constants and the CRC step function of the RC channel frame decoder.
package rcfd_pkg;

  localparam int NUM_CHANNELS_DEF    = 16;
  localparam int MAX_FRAME_BYTES_DEF = 48;

  localparam logic [7:0] SYNC_BYTE        = 8'h3E;
  localparam logic [7:0] REQ_REPLY        = 8'h01;
  localparam logic [7:0] REQ_NOREPLY      = 8'h03;
  localparam logic [7:0] DATA_ID_CHANNELS = 8'h31;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [7:0] REG_GAP_TIMEOUT      = 8'd0;
  localparam logic [7:0] REG_FAILSAFE_TIMEOUT = 8'd1;
  localparam logic [7:0] REG_BAUD_LIMIT       = 8'd2;
  localparam logic [7:0] REG_TIMEOUT_MARKER   = 8'd3;

  localparam logic [1:0] FRAME_NONE = 2'd0;
  localparam logic [1:0] FRAME_GOOD = 2'd1;
  localparam logic [1:0] FRAME_BAD  = 2'd2;

  localparam logic [7:0]  GAP_TIMEOUT_RST      = 8'd4;
  localparam logic [7:0]  FAILSAFE_TIMEOUT_RST = 8'd64;
  localparam logic [7:0]  BAUD_LIMIT_RST       = 8'd64;
  localparam logic [15:0] TIMEOUT_MARKER_RST   = 16'd65534;

  // Quality in unsigned Q7.8 percent; a good frame pulls toward 100.
  localparam logic [18:0] QUALITY_GOOD_TERM = 19'd25600;
  localparam logic [18:0] QUALITY_ROUND     = 19'd10;
  // ceil(2^20 / 5): exact quotient for operands below 2^18.
  localparam logic [17:0] RECIP_FIVE        = 18'd209716;

  localparam int OUT_TDATA_W = 32;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic q_mul;
    logic q_fin;
    logic rd_lo;
    logic rd_hi;
    logic wr_ch;
    logic load_out;
  } rcfd_cmd_t;

  typedef struct packed {
    logic complete;
    logic good;
    logic walk_end;
  } rcfd_st_t;

  // One byte of the reflected CRC-16, polynomial 0x8408.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ {d[3:0], 4'b0000};
    return {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b000};
  endfunction

endpackage

// ===== hw/rtl/rcfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

// ===== hw/rtl/rcfd_ctrl.sv =====
// Controller state machine that sequences each item through the datapath.
module rcfd_ctrl
  import rcfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  rcfd_st_t  st,
  output rcfd_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_POST = 3'd2;
  localparam logic [2:0] S_QMUL = 3'd3;
  localparam logic [2:0] S_QFIN = 3'd4;
  localparam logic [2:0] S_WLO  = 3'd5;
  localparam logic [2:0] S_WHI  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       wwr_r, wwr_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    wwr_nxt       = 1'b0;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_POST;
      end
      S_POST: begin
        state_nxt = st.complete ? S_QMUL : S_DONE;
      end
      S_QMUL: begin
        cmd.q_mul = 1'b1;
        state_nxt = S_QFIN;
      end
      S_QFIN: begin
        cmd.q_fin = 1'b1;
        state_nxt = st.good ? S_WLO : S_DONE;
      end
      S_WLO: begin
        // The previous word is written here before the next low-byte read.
        cmd.wr_ch = wwr_r;
        if (!wwr_r && st.walk_end) begin
          state_nxt = S_DONE;
        end else if (!wwr_r) begin
          cmd.rd_lo = 1'b1;
          state_nxt = S_WHI;
        end else begin
          state_nxt = S_WLO;
        end
      end
      S_WHI: begin
        cmd.rd_hi = 1'b1;
        wwr_nxt   = 1'b1;
        state_nxt = S_WLO;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wwr_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wwr_r       <= wwr_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EXEC))
    else $error("accepted item did not move to execution");

  a_walk_good: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WLO || state_r == S_WHI) |-> st.good)
    else $error("channel unpack running on a bad frame");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken result");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_tready) |=> (state_r == S_DONE))
    else $error("finished item left while output stalled");

endmodule

// ===== hw/rtl/rcfd_datapath.sv =====
// Datapath: framing, CRC, timers, channel store, quality filter and result register.
module rcfd_datapath
  import rcfd_pkg::*;
#(
  parameter int NUM_CHANNELS    = NUM_CHANNELS_DEF,
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rcfd_cmd_t              cmd,
  output rcfd_st_t               st,
  input  logic [15:0]            in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   cfg_wr,
  input  logic [7:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW  = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
  localparam int BCW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int NCW = $clog2(NUM_CHANNELS + 1);
  localparam int CIW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [BCW-1:0] MAX_CNT = BCW'(MAX_FRAME_BYTES);
  localparam logic [7:0]     MAX_LEN = 8'(MAX_FRAME_BYTES);
  localparam logic [7:0]     NUM_CH8 = 8'(NUM_CHANNELS);

  logic [1:0]  op_r;
  logic [7:0]  byte_r, idx_r;
  logic [7:0]  gap_to_r, fs_to_r, lim_r;
  logic [15:0] marker_r;

  logic [BCW-1:0] cnt_r;
  logic [7:0]     exp_r;
  logic [15:0]    crc_r;
  logic           in_frame_r, req_ok_r, id_ok_r;
  logic [NCW-1:0] nch_r, wch_r;
  logic [7:0]     gap_r, fst_r, fsc_r;
  logic           baud_r;
  logic [14:0]    q_r;
  logic           complete_r, good_r;
  logic [7:0]     lo_r;
  logic [34:0]    prod_r;
  logic [15:0]    chan_r [NUM_CHANNELS];

  logic [15:0] val_r;
  logic        inv_r, fsev_r, bchg_r;
  logic [1:0]  fres_r;
  logic [OUT_TDATA_W-1:0] out_r;

  // Frame store
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  // Byte path
  logic [BCW-1:0] cnt_inc;
  logic [7:0]     cnt_inc8, exp_new;
  logic [15:0]    crc_new;
  logic           req_new, id_new;
  logic [NCW-1:0] nch_new;

  // Tick path
  logic [7:0] gap_inc, fst_inc, fsc_inc;
  logic       gap_fire, fs_fire, baud_fire;

  // Walk
  logic [7:0] pos;
  logic [7:0] pos_hi;
  logic [7:0] hi_byte;
  logic [15:0] word;

  logic [18:0] q_sum;
  logic [15:0] q_round;

  assign cnt_inc  = cnt_r + BCW'(1);
  assign cnt_inc8 = 8'(cnt_inc);
  assign exp_new  = (cnt_inc8 == 8'd3) ? byte_r : exp_r;
  assign crc_new  = crc_step(in_frame_r ? crc_r : 16'h0000, byte_r);
  assign req_new  = (cnt_r == BCW'(1)) ? (byte_r == REQ_REPLY || byte_r == REQ_NOREPLY)
                                       : req_ok_r;
  assign id_new   = (cnt_r == BCW'(4)) ? (byte_r == DATA_ID_CHANNELS) : id_ok_r;
  always_comb begin
    if (cnt_r == BCW'(5)) begin
      nch_new = ({1'b0, byte_r[7:1]} > NUM_CH8) ? NCW'(NUM_CHANNELS) : NCW'(byte_r[7:1]);
    end else begin
      nch_new = nch_r;
    end
  end

  assign gap_inc   = (gap_r == 8'hFF) ? 8'hFF : gap_r + 8'd1;
  assign fst_inc   = (fst_r == 8'hFF) ? 8'hFF : fst_r + 8'd1;
  assign fsc_inc   = (fsc_r == 8'hFF) ? 8'hFF : fsc_r + 8'd1;
  assign gap_fire  = gap_inc > gap_to_r;
  assign fs_fire   = fst_inc > fs_to_r;
  assign baud_fire = fsc_inc >= lim_r;

  assign pos     = 8'd6 + 8'({wch_r, 1'b0});
  assign pos_hi  = pos + 8'd1;
  assign hi_byte = (pos_hi < exp_r) ? ram_rdata : 8'h00;
  assign word    = {hi_byte, lo_r} >> 3;

  assign ram_we    = cmd.exec && (op_r == OP_BYTE) &&
                     ((!in_frame_r && byte_r == SYNC_BYTE) || (in_frame_r && cnt_r < MAX_CNT));
  assign ram_waddr = in_frame_r ? cnt_r[AW-1:0] : '0;
  assign ram_raddr = cmd.rd_hi ? pos_hi[AW-1:0] : pos[AW-1:0];

  rcfd_ram #(.WIDTH(8), .DEPTH(MAX_FRAME_BYTES)) u_frame_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (byte_r),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign q_sum   = {q_r, 4'b0000} + {3'b000, q_r, 1'b0} + {4'b0000, q_r} +
                   (good_r ? QUALITY_GOOD_TERM : 19'd0) + QUALITY_ROUND;
  assign q_round = {1'b0, q_r} + 16'd128;

  assign st.complete = complete_r;
  assign st.good     = good_r;
  assign st.walk_end = (wch_r >= nch_r) || (pos >= exp_r);

  assign out_tdata = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_to_r   <= GAP_TIMEOUT_RST;
      fs_to_r    <= FAILSAFE_TIMEOUT_RST;
      lim_r      <= BAUD_LIMIT_RST;
      marker_r   <= TIMEOUT_MARKER_RST;
      cnt_r      <= '0;
      exp_r      <= MAX_LEN;
      crc_r      <= '0;
      in_frame_r <= 1'b0;
      req_ok_r   <= 1'b0;
      id_ok_r    <= 1'b1;
      nch_r      <= '0;
      wch_r      <= '0;
      gap_r      <= '0;
      fst_r      <= '0;
      fsc_r      <= '0;
      baud_r     <= 1'b0;
      q_r        <= '0;
      complete_r <= 1'b0;
      good_r     <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_r[i] <= TIMEOUT_MARKER_RST;
      end
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_GAP_TIMEOUT:      gap_to_r <= cfg_data[7:0];
          REG_FAILSAFE_TIMEOUT: fs_to_r  <= cfg_data[7:0];
          REG_BAUD_LIMIT:       lim_r    <= cfg_data[7:0];
          REG_TIMEOUT_MARKER:   marker_r <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.exec) begin
        complete_r <= 1'b0;
        wch_r      <= '0;
        case (op_r)
          OP_BYTE: begin
            gap_r <= '0;
            if (!in_frame_r) begin
              if (byte_r == SYNC_BYTE) begin
                in_frame_r <= 1'b1;
                exp_r      <= MAX_LEN;
                crc_r      <= crc_new;
                cnt_r      <= BCW'(1);
                req_ok_r   <= 1'b0;
                id_ok_r    <= 1'b1;
                nch_r      <= '0;
              end
            end else if (cnt_r < MAX_CNT) begin
              crc_r    <= crc_new;
              cnt_r    <= cnt_inc;
              exp_r    <= exp_new;
              req_ok_r <= req_new;
              id_ok_r  <= id_new;
              nch_r    <= nch_new;
              if (cnt_inc8 == exp_new) begin
                // Sync is always the first stored byte, so it needs no check.
                complete_r <= 1'b1;
                good_r     <= (crc_new == 16'h0000) && req_new && id_new;
                in_frame_r <= 1'b0;
                if ((crc_new == 16'h0000) && req_new && id_new) begin
                  fst_r <= '0;
                  fsc_r <= '0;
                end
              end
            end else begin
              in_frame_r <= 1'b0;
            end
          end
          OP_TICK: begin
            if (gap_fire) begin
              in_frame_r <= 1'b0;
              cnt_r      <= '0;
              gap_r      <= '0;
              exp_r      <= MAX_LEN;
            end else begin
              gap_r <= gap_inc;
            end
            if (fs_fire) begin
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                chan_r[i] <= marker_r;
              end
              fst_r <= '0;
              q_r   <= '0;
              if (baud_fire) begin
                baud_r <= !baud_r;
                fsc_r  <= '0;
              end else begin
                fsc_r <= fsc_inc;
              end
            end else begin
              fst_r <= fst_inc;
            end
          end
          default: ;
        endcase
      end

      if (cmd.q_fin) begin
        q_r <= prod_r[34:20];
      end
      if (cmd.wr_ch) begin
        chan_r[wch_r[CIW-1:0]] <= word;
        wch_r <= wch_r + NCW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r   <= in_tuser;
      byte_r <= in_tdata[7:0];
      idx_r  <= in_tdata[15:8];
    end
    if (cmd.exec) begin
      val_r  <= '0;
      inv_r  <= 1'b0;
      fres_r <= FRAME_NONE;
      fsev_r <= (op_r == OP_TICK) && fs_fire;
      bchg_r <= (op_r == OP_TICK) && fs_fire && baud_fire;
      if (op_r == OP_READ) begin
        if (idx_r >= NUM_CH8) begin
          inv_r <= 1'b1;
        end else begin
          val_r <= chan_r[idx_r[CIW-1:0]];
        end
      end
      if (op_r == OP_BYTE && in_frame_r && cnt_r < MAX_CNT && cnt_inc8 == exp_new) begin
        fres_r <= ((crc_new == 16'h0000) && req_new && id_new) ? FRAME_GOOD : FRAME_BAD;
      end
    end
    if (cmd.q_mul) begin
      // Divide by 20 as a shift by two and a multiply by the reciprocal of five.
      prod_r <= 35'(q_sum[18:2]) * 35'(RECIP_FIVE);
    end
    if (cmd.rd_hi) begin
      lo_r <= ram_rdata;
    end
    if (cmd.load_out) begin
      out_r <= {3'b000, bchg_r, baud_r, fsev_r, q_round[14:8], fres_r, inv_r, val_r};
    end
  end

endmodule

// ===== hw/rtl/rc_channel_frame_decoder.sv =====
// Top level of the RC channel frame decoder: controller, datapath and port glue.
//
// Usage: items arrive on the in_ stream. in_tuser carries the operation (received
// byte, supervisor tick or channel read), in_tdata the byte and the channel index.
// Each accepted item yields exactly one result item on the out_ stream, carrying
// the read channel value, an invalid-index flag, the frame verdict, the link
// quality in percent, the failsafe and baud-toggle flags and the current baud.
// Configuration registers are written through the cfg_ port, which is always
// ready; write it only while no item is in flight.
// Sequencing: a tick, a read or a byte that does not end a frame passes the execute
// and post states before its result is loaded. A byte that ends a frame adds the
// quality filter multiply and finish states, and a good frame then walks the frame
// RAM channel word by channel word. The single read port of the frame RAM reads the
// low and then the high byte of each word, and the word is written after them.
// One item is processed at a time; the next item is accepted once the previous
// one has been placed in the output register, even while that result waits.
// Reset: synchronous, active low; the channels read as the default timeout
// marker, the timers and quality clear and the link starts at the low baud rate.
// When the receiver stalls, the finished item holds in the output register and
// the following item waits just before its own result is loaded.
module rc_channel_frame_decoder
  import rcfd_pkg::*;
#(
  parameter int NUM_CHANNELS    = NUM_CHANNELS_DEF,
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [7:0] byte_value, [15:8] channel_index
  input  logic [15:0]            in_tdata,
  // [1:0] op
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] channel_value, [16] channel_invalid, [18:17] frame_result,
  // [25:19] link_quality, [26] failsafe_event, [27] high_baud,
  // [28] baud_changed, [31:29] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  rcfd_cmd_t cmd;
  rcfd_st_t  st;

  // Registers are plain flip-flops, so a write is always taken at once.
  assign cfg_ready = 1'b1;

  rcfd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  rcfd_datapath #(
    .NUM_CHANNELS    (NUM_CHANNELS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the RC channel frame decoder with a scoreboard class.
`timescale 1ns / 1ps

module tb_top;
  import rcfd_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;
  localparam int MAXB = MAX_FRAME_BYTES_DEF;
  localparam int STALL_LIMIT = 2000;
  // Operation code with no meaning; the block leaves its state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One expected result item, field by field.
  typedef struct {
    logic [15:0] chan_value;
    logic        chan_invalid;
    logic [1:0]  verdict;
    logic [6:0]  quality;
    logic        failsafe;
    logic        baud_high;
    logic        baud_toggled;
  } decode_result_t;

  // The scoreboard keeps its own copy of the decoder state and predicts one
  // result per accepted item; results are checked in order against it.
  class decoder_scoreboard;
    logic [7:0]  gap_limit, fs_limit, baud_limit;
    logic [15:0] marker;
    logic [7:0]  frame_bytes [MAXB];
    logic [15:0] channels [NCH];
    int unsigned count, frame_len, gap_cnt, fs_cnt, fs_events, q_fix;
    logic [15:0] crc;
    bit          framing, baud_hi;
    decode_result_t pending [$];
    int          errors;

    function void reset_state();
      gap_limit = GAP_TIMEOUT_RST;
      fs_limit = FAILSAFE_TIMEOUT_RST;
      baud_limit = BAUD_LIMIT_RST;
      marker = TIMEOUT_MARKER_RST;
      foreach (channels[i]) channels[i] = marker;
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      count = 0; frame_len = MAXB; crc = 16'h0; framing = 0;
      gap_cnt = 0; fs_cnt = 0; fs_events = 0; baud_hi = 0; q_fix = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] val);
      case (idx)
        REG_GAP_TIMEOUT:      gap_limit = val[7:0];
        REG_FAILSAFE_TIMEOUT: fs_limit = val[7:0];
        REG_BAUD_LIMIT:       baud_limit = val[7:0];
        REG_TIMEOUT_MARKER:   marker = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      logic [7:0] d;
      d = b ^ c[7:0];
      d = d ^ (d << 4);
      return {d, c[15:8]} ^ (d >> 4) ^ ({8'h00, d} << 3);
    endfunction

    function void clear_channels();
      foreach (channels[i]) channels[i] = marker;
    endfunction

    // Checks a completed frame and unpacks its channel words when it is good.
    function bit judge_frame();
      int unsigned span, words, ch, i, hi;
      logic [15:0] word;
      if (crc != 16'h0) return 0;
      span = (frame_len > MAXB) ? MAXB : frame_len;
      words = 0; ch = 0; i = 0;
      while (i < span) begin
        if (i == 0) begin
          if (frame_bytes[0] != SYNC_BYTE) return 0;
          i++;
        end else if (i == 1) begin
          if (frame_bytes[1] != REQ_REPLY && frame_bytes[1] != REQ_NOREPLY) return 0;
          i++;
        end else if (i == 2 || i == 3) begin
          i++;
        end else if (i == 4) begin
          if (frame_bytes[4] != DATA_ID_CHANNELS) return 0;
          i++;
        end else if (i == 5) begin
          words = frame_bytes[5] / 2;
          if (words > NCH) words = NCH;
          i++;
        end else begin
          if (ch < words) begin
            hi = (i + 1 < span) ? frame_bytes[i + 1] : 0;
            word = {hi[7:0], frame_bytes[i]};
            channels[ch] = word >> 3;
            ch++;
          end
          i += 2;
        end
      end
      return 1;
    endfunction

    function int unsigned sat_inc(int unsigned v);
      return (v >= 255) ? 255 : v + 1;
    endfunction

    function void note_item(logic [1:0] op, logic [7:0] data_byte, logic [7:0] chan);
      decode_result_t r;
      bit good;
      r = '{default: '0};
      if (op == OP_BYTE) begin
        if (!framing) begin
          if (data_byte == SYNC_BYTE) begin
            framing = 1; frame_len = MAXB;
            crc = crc_byte(16'h0, data_byte);
            frame_bytes[0] = data_byte; count = 1;
          end
        end else if (count < MAXB) begin
          crc = crc_byte(crc, data_byte);
          frame_bytes[count] = data_byte;
          count++;
          if (count == 3) frame_len = data_byte;
          if (count == frame_len) begin
            good = judge_frame();
            if (good) begin
              fs_cnt = 0; fs_events = 0;
              r.verdict = FRAME_GOOD;
            end else begin
              r.verdict = FRAME_BAD;
            end
            q_fix = (q_fix * 19 + (good ? 25600 : 0) + 10) / 20;
            framing = 0;
          end
        end else begin
          framing = 0;
        end
        gap_cnt = 0;
      end else if (op == OP_TICK) begin
        gap_cnt = sat_inc(gap_cnt);
        if (gap_cnt > gap_limit) begin
          framing = 0; count = 0; gap_cnt = 0; frame_len = MAXB;
        end
        fs_cnt = sat_inc(fs_cnt);
        if (fs_cnt > fs_limit) begin
          clear_channels();
          fs_cnt = 0; q_fix = 0; r.failsafe = 1;
          fs_events = sat_inc(fs_events);
          if (fs_events >= baud_limit) begin
            baud_hi = !baud_hi; fs_events = 0; r.baud_toggled = 1;
          end
        end
      end else if (op == OP_READ) begin
        if (chan >= NCH) r.chan_invalid = 1;
        else r.chan_value = channels[chan];
      end
      r.quality = 7'((q_fix + 128) >> 8);
      r.baud_high = baud_hi;
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      decode_result_t e;
      if (pending.size() == 0) begin
        $error("result item with no expectation: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.chan_value) begin
        $error("channel_value exp %0d got %0d", e.chan_value, d[15:0]); errors++;
      end
      if (d[16] !== e.chan_invalid) begin
        $error("channel_invalid exp %0d got %0d", e.chan_invalid, d[16]); errors++;
      end
      if (d[18:17] !== e.verdict) begin
        $error("frame_result exp %0d got %0d", e.verdict, d[18:17]); errors++;
      end
      if (d[25:19] !== e.quality) begin
        $error("link_quality exp %0d got %0d", e.quality, d[25:19]); errors++;
      end
      if (d[26] !== e.failsafe) begin
        $error("failsafe_event exp %0d got %0d", e.failsafe, d[26]); errors++;
      end
      if (d[27] !== e.baud_high) begin
        $error("high_baud exp %0d got %0d", e.baud_high, d[27]); errors++;
      end
      if (d[28] !== e.baud_toggled) begin
        $error("baud_changed exp %0d got %0d", e.baud_toggled, d[28]); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid, out_tready = 0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 0, cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Random idling on both sides is switched off for the closing stretch.
  bit idle_on = 1;
  int stall_cycles = 0;
  decoder_scoreboard sb;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  rc_channel_frame_decoder i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Results are checked at the edge that accepts them. The receiver stalls in
  // random bursts.
  int rx_hold = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_tready <= 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rx_hold <= $urandom_range(0, 4);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  // The watchdog ends the run when no item moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Sends one item and waits for its acceptance; the scoreboard predicts it then.
  // The valid line goes low after each item before the next item is driven.
  task automatic send_item(logic [1:0] op, logic [7:0] data_byte, logic [7:0] chan);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {chan, data_byte};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, data_byte, chan);
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic read_channel(logic [7:0] chan);
    send_item(OP_READ, 8'($urandom_range(0, 255)), chan);
  endtask

  task automatic send_frame_byte(logic [7:0] b);
    send_item(OP_BYTE, b, 8'($urandom_range(0, 255)));
  endtask

  // Waits until every expected result has come, plus the longest frame walk.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Builds a frame with a closing CRC that leaves a zero residue, unless corrupt
  // flips a bit. The channel count byte may claim more words than the frame holds.
  task automatic send_frame(int n_words, logic [7:0] req, logic [7:0] data_id,
                            logic [7:0] count_byte, bit corrupt);
    logic [7:0] buf_bytes [MAXB];
    logic [15:0] c;
    int len;
    len = 6 + 2 * n_words + 2;
    if (len > MAXB) len = MAXB;
    buf_bytes[0] = SYNC_BYTE;
    buf_bytes[1] = req;
    buf_bytes[2] = 8'(len);
    buf_bytes[3] = 8'($urandom_range(0, 255));
    buf_bytes[4] = data_id;
    buf_bytes[5] = count_byte;
    for (int i = 6; i < len - 2; i++) buf_bytes[i] = 8'($urandom_range(0, 255));
    c = 16'h0;
    for (int i = 0; i < len - 2; i++) c = sb.crc_byte(c, buf_bytes[i]);
    buf_bytes[len - 2] = c[7:0];
    buf_bytes[len - 1] = c[15:8];
    if (corrupt) buf_bytes[$urandom_range(3, len - 1)] ^= 8'h01 << $urandom_range(0, 7);
    for (int i = 0; i < len; i++) send_frame_byte(buf_bytes[i]);
  endtask

  task automatic good_frame();
    int w;
    w = $urandom_range(0, 20);
    send_frame(w, ($urandom_range(0, 1) != 0) ? REQ_REPLY : REQ_NOREPLY, DATA_ID_CHANNELS,
               ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'(2 * w), 1'b0);
  endtask

  // Frames with a wrong header field but a valid CRC.
  task automatic header_fault_frame();
    logic [7:0] req, id;
    req = ($urandom_range(0, 1) != 0) ? REQ_REPLY : REQ_NOREPLY;
    id = DATA_ID_CHANNELS;
    if ($urandom_range(0, 1) != 0) req = 8'($urandom_range(0, 255));
    else id = 8'($urandom_range(0, 255));
    send_frame($urandom_range(0, 16), req, id, 8'($urandom_range(0, 40)), 1'b0);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) good_frame();
    else if (pick < 45) send_frame($urandom_range(0, 16), REQ_REPLY, DATA_ID_CHANNELS,
                                   8'($urandom_range(0, 40)), 1'b1);
    else if (pick < 52) header_fault_frame();
    else if (pick < 65) send_frame_byte(8'($urandom_range(0, 255)));
    else if (pick < 82) send_tick();
    else if (pick < 96) read_channel(8'($urandom_range(0, NCH - 1)));
    else if (pick < 98) read_channel(8'($urandom_range(0, 255)));
    else send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  int sent;

  initial begin
    sb = new();
    sb.reset_state();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: reads at the index extremes, unknown op, stray bytes, a short
    // length byte that ends by overrun, a good frame, a short frame whose count
    // byte claims words it lacks, and a frame holding more words than channels.
    read_channel(8'd0);
    read_channel(8'(NCH - 1));
    read_channel(8'(NCH));
    read_channel(8'hFF);
    send_item(OP_UNUSED, 8'hFF, 8'hFF);
    send_frame_byte(8'h00);
    send_frame_byte(8'hFF);
    send_frame_byte(SYNC_BYTE);
    send_frame_byte(REQ_REPLY);
    send_frame_byte(8'd2);
    for (int i = 0; i < MAXB; i++) send_frame_byte(8'hA5);
    send_frame(16, REQ_REPLY, DATA_ID_CHANNELS, 8'd32, 1'b0);
    send_frame(0, REQ_NOREPLY, DATA_ID_CHANNELS, 8'd40, 1'b0);
    send_frame(20, REQ_REPLY, DATA_ID_CHANNELS, 8'hFF, 1'b0);
    for (int i = 0; i < NCH; i++) read_channel(8'(i));
    drain();

    // Extremes of the registers: lowest limits, so a timer fires on its second tick.
    write_reg(REG_GAP_TIMEOUT, 16'd1);
    write_reg(REG_FAILSAFE_TIMEOUT, 16'd1);
    write_reg(REG_BAUD_LIMIT, 16'd1);
    write_reg(REG_TIMEOUT_MARKER, 16'h0000);
    for (sent = 0; sent < 20; sent++) random_item();
    drain();

    write_reg(REG_GAP_TIMEOUT, 16'd255);
    write_reg(REG_FAILSAFE_TIMEOUT, 16'd255);
    write_reg(REG_BAUD_LIMIT, 16'd255);
    write_reg(REG_TIMEOUT_MARKER, 16'hFFFF);
    for (sent = 0; sent < 20; sent++) random_item();
    // A long run of ticks lets the timers reach their saturation limit.
    for (sent = 0; sent < 300; sent++) send_tick();
    drain();

    write_reg(REG_GAP_TIMEOUT, 16'($urandom_range(2, 6)));
    write_reg(REG_FAILSAFE_TIMEOUT, 16'($urandom_range(3, 20)));
    write_reg(REG_BAUD_LIMIT, 16'($urandom_range(2, 4)));
    write_reg(REG_TIMEOUT_MARKER, 16'($urandom_range(0, 65535)));
    for (sent = 0; sent < 30; sent++) random_item();
    drain();

    write_reg(REG_TIMEOUT_MARKER, 16'h5A5A);
    for (sent = 0; sent < 15; sent++) random_item();
    idle_on = 0;
    for (sent = 0; sent < 15; sent++) random_item();
    drain();

    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
